// ===== hw/rtl/rgb_pixel_buffer_engine_assert.svh =====
// Assertion macros for the RGB pixel buffer engine.
// Used by the controller and datapath; expects clk_i and rst_ni in scope.
`ifndef RGB_PIXEL_BUFFER_ENGINE_ASSERT_SVH
`define RGB_PIXEL_BUFFER_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define RPBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define RPBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RPBE_ASSERT(lbl, prop, msg)
`define RPBE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/rpbe_pkg.sv =====
// Shared types and constants for the RGB pixel buffer engine.
// No dependencies; imported by every module of the block except rpbe_ram.
`default_nettype none

package rpbe_pkg;

  // buffer geometry
  localparam int PIXELS    = 32;
  localparam int BUF_BYTES = 3 * PIXELS;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  // sweep index also reaches BUF_BYTES+2 during a rotate
  localparam int IDX_W     = $clog2(BUF_BYTES + 3);

  // command codes
  typedef enum logic [2:0] {
    MODE_WRITE  = 3'd0,
    MODE_FILL   = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_ROTATE = 3'd3,
    MODE_REPEAT = 3'd4,
    MODE_READ   = 3'd5
  } mode_e;

  // source of the byte written in the second stage
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_BYTE,
    SRC_COLOUR,
    SRC_ADD,
    SRC_RDATA,
    SRC_SAVED
  } src_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SWEEP,
    ST_DRAIN,
    ST_RDBK,
    ST_RDWAIT,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] first_pixel;
    logic [7:0] last_pixel;
    logic [9:0] byte_offset;
    logic [9:0] period;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  typedef struct packed {
    logic       status;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic clr;
    logic rb_init;
    logic rb;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_sweep;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rpbe_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module rpbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rpbe_ctrl.sv =====
// Controller state machine of the RGB pixel buffer engine.
// Depends on rpbe_pkg; sequences rpbe_dp through dp_cmd_t / dp_sts_t.
`default_nettype none
`include "rgb_pixel_buffer_engine_assert.svh"

module rpbe_ctrl import rpbe_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.need_sweep) begin
          state_d = ST_SWEEP;
        end else begin
          cmd_o.rb_init = 1'b1;
          state_d       = ST_RDBK;
        end
      end
      ST_SWEEP: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = ST_DRAIN;
        end
      end
      // last write of the sweep lands here
      ST_DRAIN: begin
        cmd_o.rb_init = 1'b1;
        state_d       = ST_RDBK;
      end
      ST_RDBK: begin
        cmd_o.rb = 1'b1;
        if (sts_i.last) begin
          state_d = ST_RDWAIT;
        end
      end
      ST_RDWAIT: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // checks
  `RPBE_ASSERT(a_out_no_overwrite, cmd_o.out_load |-> (!out_valid_q || out_ready_i), "result word overwritten before taken")
  `RPBE_ASSERT(a_single_issue, (cmd_o.step || cmd_o.clr) |-> !cmd_o.rb, "two buffer issues in one cycle")
  `RPBE_ASSERT_ALWAYS(a_no_accept_in_clear, (state_q == ST_CLEAR) |-> !in_ready_o, "word accepted during clearing pass")

endmodule

`default_nettype wire

// ===== hw/rtl/rpbe_dp.sv =====
// Datapath of the RGB pixel buffer engine: buffer RAM, sweep counters,
// two-stage read/modify/write pipe and result register. Uses rpbe_pkg, rpbe_ram.
`default_nettype none
`include "rgb_pixel_buffer_engine_assert.svh"

module rpbe_dp import rpbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  input  in_word_t  in_word_i,
  output out_word_t out_word_o
);

  // captured command
  logic [2:0]       mode_q;
  logic [7:0]       first_q;
  logic             first_ok_q;
  logic [7:0]       col_q [3];
  logic [IDX_W-1:0] per_q;
  logic             status_q;
  logic             need_sweep_q;

  // sweep counters
  logic [IDX_W-1:0] idx_q, idx_d, end_q, end_d, rp_q, rp_d;
  logic [1:0]       ch_q, ch_d;

  // load decode
  logic [9:0]       in_first3, in_last3, q_first3;
  logic [10:0]      in_waddr;
  logic             in_first_ok, in_last_ok, in_range_ok, in_per_ok;
  logic             ld_sweep, ld_status;
  logic [IDX_W-1:0] ld_idx, ld_end, rb_idx;

  // issue stage
  logic              issue, rd_use, idx_in_buf;
  logic [ADDR_W-1:0] idx_a, ra, iss_wa;
  logic              iss_we, iss_cap_sav, iss_cap_out;
  src_e              iss_src;

  // write stage
  logic              s1_we_q, s1_cap_sav_q, s1_cap_out_q;
  logic [ADDR_W-1:0] s1_wa_q;
  src_e              s1_src_q;
  logic [1:0]        s1_ch_q;
  logic [7:0]        rdata, wdata, col_sel, sav_sel;
  logic [7:0]        sav_q [3];
  logic [7:0]        pix_q [3];
  out_word_t         out_q;

  // decode of the incoming word
  assign in_first3   = {1'b0, in_word_i.first_pixel, 1'b0} + {2'b00, in_word_i.first_pixel};
  assign in_last3    = {1'b0, in_word_i.last_pixel, 1'b0} + {2'b00, in_word_i.last_pixel};
  assign in_waddr    = {1'b0, in_first3} + {1'b0, in_word_i.byte_offset};
  assign in_first_ok = {2'b00, in_word_i.first_pixel} < 10'(PIXELS);
  assign in_last_ok  = {2'b00, in_word_i.last_pixel} < 10'(PIXELS);
  assign in_range_ok = in_first_ok && in_last_ok &&
                       (in_word_i.last_pixel >= in_word_i.first_pixel);
  assign in_per_ok   = (in_word_i.period != 10'd0) && (in_word_i.period < 10'(BUF_BYTES));

  always_comb begin
    ld_sweep  = 1'b0;
    ld_status = 1'b0;
    ld_idx    = '0;
    ld_end    = '0;
    unique case (in_word_i.mode)
      MODE_WRITE: begin
        ld_sweep = in_waddr < 11'(BUF_BYTES);
        ld_idx   = IDX_W'(in_waddr);
        ld_end   = IDX_W'(in_waddr);
      end
      MODE_FILL, MODE_ADD: begin
        ld_sweep  = in_range_ok;
        ld_status = !in_range_ok;
        ld_idx    = IDX_W'(in_first3);
        ld_end    = IDX_W'(in_last3 + 10'd2);
      end
      MODE_ROTATE: begin
        ld_sweep = 1'b1;
        ld_idx   = '0;
        ld_end   = IDX_W'(BUF_BYTES + 2);
      end
      MODE_REPEAT: begin
        ld_sweep = in_per_ok;
        ld_idx   = IDX_W'(in_word_i.period);
        ld_end   = IDX_W'(BUF_BYTES - 1);
      end
      default: begin
        ld_sweep = 1'b0;
      end
    endcase
  end

  // readback start address
  assign q_first3 = {1'b0, first_q, 1'b0} + {2'b00, first_q};
  assign rb_idx   = first_ok_q ? IDX_W'(q_first3) : '0;

  // issue: read address, write target and byte source
  assign idx_in_buf = idx_q < IDX_W'(BUF_BYTES);
  assign idx_a      = ADDR_W'(idx_q);

  always_comb begin
    iss_we      = 1'b0;
    iss_wa      = idx_a;
    iss_src     = SRC_ZERO;
    ra          = '0;
    rd_use      = 1'b0;
    iss_cap_sav = 1'b0;
    iss_cap_out = 1'b0;
    if (cmd_i.clr) begin
      iss_we = 1'b1;
    end else if (cmd_i.rb) begin
      ra          = idx_a;
      rd_use      = 1'b1;
      iss_cap_out = 1'b1;
    end else if (cmd_i.step) begin
      unique case (mode_q)
        MODE_WRITE: begin
          iss_we  = 1'b1;
          iss_src = SRC_BYTE;
        end
        MODE_FILL: begin
          iss_we  = 1'b1;
          iss_src = SRC_COLOUR;
        end
        MODE_ADD: begin
          ra      = idx_a;
          rd_use  = 1'b1;
          iss_we  = 1'b1;
          iss_src = SRC_ADD;
        end
        // read i, write i-3; first three bytes saved for the tail
        MODE_ROTATE: begin
          if (idx_in_buf) begin
            ra     = idx_a;
            rd_use = 1'b1;
          end
          iss_we      = idx_q >= IDX_W'(3);
          iss_wa      = ADDR_W'(idx_q - IDX_W'(3));
          iss_src     = idx_in_buf ? SRC_RDATA : SRC_SAVED;
          iss_cap_sav = idx_q < IDX_W'(3);
        end
        // byte k takes original byte k mod period, never rewritten
        MODE_REPEAT: begin
          ra      = ADDR_W'(rp_q);
          rd_use  = 1'b1;
          iss_we  = 1'b1;
          iss_src = SRC_RDATA;
        end
        default: begin
          iss_we = 1'b0;
        end
      endcase
    end
  end

  assign issue = cmd_i.clr || cmd_i.rb || cmd_i.step;

  // counter next values
  always_comb begin
    idx_d = idx_q;
    end_d = end_q;
    ch_d  = ch_q;
    rp_d  = rp_q;
    if (cmd_i.load) begin
      idx_d = ld_idx;
      end_d = ld_end;
      ch_d  = 2'd0;
      rp_d  = '0;
    end else if (cmd_i.rb_init) begin
      idx_d = rb_idx;
      end_d = rb_idx + IDX_W'(2);
      ch_d  = 2'd0;
    end else if (issue) begin
      idx_d = idx_q + IDX_W'(1);
      ch_d  = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      rp_d  = (rp_q + IDX_W'(1) == per_q) ? '0 : rp_q + IDX_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      end_q        <= IDX_W'(BUF_BYTES - 1);
      ch_q         <= 2'd0;
      rp_q         <= '0;
      mode_q       <= MODE_READ;
      need_sweep_q <= 1'b0;
      s1_we_q      <= 1'b0;
      s1_cap_sav_q <= 1'b0;
      s1_cap_out_q <= 1'b0;
    end else begin
      idx_q        <= idx_d;
      end_q        <= end_d;
      ch_q         <= ch_d;
      rp_q         <= rp_d;
      s1_we_q      <= iss_we;
      s1_cap_sav_q <= iss_cap_sav;
      s1_cap_out_q <= iss_cap_out;
      if (cmd_i.load) begin
        mode_q       <= in_word_i.mode;
        need_sweep_q <= ld_sweep;
      end
    end
  end

  // captured command payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      first_q    <= in_word_i.first_pixel;
      first_ok_q <= in_first_ok;
      col_q[0]   <= in_word_i.red;
      col_q[1]   <= in_word_i.green;
      col_q[2]   <= in_word_i.blue;
      per_q      <= IDX_W'(in_word_i.period);
      status_q   <= ld_status;
    end
  end

  // write stage payload
  always_ff @(posedge clk_i) begin
    s1_wa_q  <= iss_wa;
    s1_src_q <= iss_src;
    s1_ch_q  <= ch_q;
  end

  // channel selects
  always_comb begin
    case (s1_ch_q)
      2'd0:    begin col_sel = col_q[0]; sav_sel = sav_q[0]; end
      2'd1:    begin col_sel = col_q[1]; sav_sel = sav_q[1]; end
      default: begin col_sel = col_q[2]; sav_sel = sav_q[2]; end
    endcase
  end

  // write data
  always_comb begin
    case (s1_src_q)
      SRC_ZERO:   wdata = 8'd0;
      SRC_BYTE:   wdata = col_q[0];
      SRC_COLOUR: wdata = col_sel;
      SRC_ADD:    wdata = rdata + col_sel;
      SRC_RDATA:  wdata = rdata;
      SRC_SAVED:  wdata = sav_sel;
      default:    wdata = 8'd0;
    endcase
  end

  rpbe_ram #(
    .WIDTH(8),
    .DEPTH(BUF_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (s1_we_q),
    .waddr_i(s1_wa_q),
    .wdata_i(wdata),
    .raddr_i(ra),
    .rdata_o(rdata)
  );

  // saved head bytes, readback pixel and result word
  always_ff @(posedge clk_i) begin
    if (s1_cap_sav_q) begin
      sav_q[s1_ch_q] <= rdata;
    end
    if (s1_cap_out_q) begin
      pix_q[s1_ch_q] <= first_ok_q ? rdata : 8'd0;
    end
    if (cmd_i.out_load) begin
      out_q.status      <= status_q;
      out_q.pixel_red   <= pix_q[0];
      out_q.pixel_green <= pix_q[1];
      out_q.pixel_blue  <= pix_q[2];
    end
  end

  assign sts_o.need_sweep = need_sweep_q;
  assign sts_o.last       = idx_q == end_q;
  assign out_word_o       = out_q;

  // checks
  `RPBE_ASSERT(a_no_rw_collision, (rd_use && s1_we_q) |-> (ra != s1_wa_q), "read of a byte being written")
  `RPBE_ASSERT(a_wr_in_range, s1_we_q |-> (int'(s1_wa_q) < BUF_BYTES), "buffer write out of range")

endmodule

`default_nettype wire

// ===== hw/rtl/rgb_pixel_buffer_engine.sv =====
// Top level of the RGB pixel buffer engine: controller plus datapath.
// Depends on rpbe_pkg, rpbe_ctrl, rpbe_dp (and rpbe_ram inside it).
//
//   channel | signals                          | word
//   --------+----------------------------------+-----------
//   command | in_valid_i, in_ready_o, in_word_i   | in_word_t
//   result  | out_valid_o, out_ready_i, out_word_o | out_word_t
//
// One command at a time; one byte of the buffer RAM is visited per cycle during a sweep.
// Nothing is swept for a read, a bad range, an ignored write or repeat, or an unused code;
// otherwise the sweep takes write 1, fill/add 3*(last-first+1), rotate 3*PIXELS+3 and
// repeat 3*PIXELS-period steps.
// After reset a clearing pass of 3*PIXELS steps zeroes the buffer; in_ready_o low.
// The next command is taken while a finished result waits in the output register.
`default_nettype none

module rgb_pixel_buffer_engine import rpbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  rpbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rpbe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_word_i (in_word_i),
    .out_word_o(out_word_o)
  );

endmodule

`default_nettype wire
